[hw/rtl/assert_macros.svh]
// Assertion macros shared by the console writer RTL.
// Included by files that carry concurrent checks; depends on nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// Property whose consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[hw/rtl/tcw_pkg.sv]
// Shared types and constants of the text console writer.
// Used by tcw_screen_ram and text_console_writer_top; depends on nothing.
package tcw_pkg;

    // Default screen geometry.
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // Field widths.
    localparam int FUNC_W    = 2;
    localparam int CHAR_W    = 8;
    localparam int ROW_W     = 5;
    localparam int COL_W     = 7;
    localparam int COLOR_W   = 4;
    localparam int CELL_W    = 16;
    localparam int CFG_IDX_W = 2;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FUNC_PRINT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SET   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd3;

    // Character codes with special meaning.
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'd0;
    localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
    localparam logic [CHAR_W-1:0] CH_NL    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FG = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG = 2'd1;

    // One command.
    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [CHAR_W-1:0]  char_code;
        logic [ROW_W-1:0]   target_row;
        logic [COL_W-1:0]   target_col;
        logic [COLOR_W-1:0] clear_bg;
    } t_cmd;

    // One result.
    typedef struct packed {
        logic [CELL_W-1:0] cell_value;
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_col;
    } t_result;

endpackage

[hw/rtl/text_console_writer_top.sv]
// Character-cell console engine: screen store, cursor, print and scroll control.
// Set cursor, null, backspace, plain print and out-of-range read raise o_done straight
// from the accepting edge; a read passes through S_READ; a newline writes spaces to the
// line end in S_LINE; a bottom-row wrap scrolls, blanking the new bottom row in S_SCROLL;
// clear sweeps every cell in S_FILL. Busy drops with o_done: one command at a time. After
// reset a clearing pass over every cell keeps busy high; results are shown for one cycle.
`include "assert_macros.svh"

module text_console_writer_top
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  t_cmd                 i_cmd,
    output logic                 busy,
    output logic                 o_done,
    output t_result              o_result,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COLOR_W-1:0]   i_cfg_data
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);

    localparam logic [ROW_W+1:0]  ROWS_C    = (ROW_W + 2)'(ROWS);
    localparam logic [COL_W:0]    COLS_C    = (COL_W + 1)'(COLUMNS);
    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] LAST_SCOL = ADDR_W'(COLUMNS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LINE,
        S_SCROLL,
        S_FILL,
        S_READ
    } t_state;

    t_state             r_state;
    logic [ROW_W-1:0]   r_cur_row;
    logic [COL_W-1:0]   r_cur_col;
    logic [ROW_W-1:0]   r_top;
    logic [ROW_W-1:0]   r_srow;
    logic [ADDR_W-1:0]  r_cnt;
    logic [CELL_W-1:0]  r_fill_data;
    logic               r_fill_report;
    logic [CELL_W-1:0]  r_cell;
    logic               r_done;
    logic [COLOR_W-1:0] r_fg;
    logic [COLOR_W-1:0] r_bg;

    logic               accept;
    logic [7:0]         cur_color;
    logic [CELL_W-1:0]  blank_cell;
    logic [COL_W-1:0]   bs_col;
    logic               rd_in_range;
    logic [ADDR_W-1:0]  cur_addr;
    logic [ADDR_W-1:0]  bs_addr;
    logic [ADDR_W-1:0]  scroll_addr;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [CELL_W-1:0]  ram_wdata;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [CELL_W-1:0]  ram_rdata;

    // Logical row to memory address; r_top is the physical row shown at the top.
    function automatic logic [ADDR_W-1:0] cell_addr(
        input logic [ROW_W-1:0] row,
        input logic [COL_W-1:0] col,
        input logic [ROW_W-1:0] top
    );
        logic [ROW_W+1:0] sum;
        sum = {2'b00, row} + {2'b00, top};
        if (sum >= ROWS_C) begin
            sum = sum - ROWS_C;
        end
        return ADDR_W'(sum) * ADDR_W'(COLUMNS) + ADDR_W'(col);
    endfunction

    assign accept      = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign cur_color   = {r_bg, r_fg};
    assign blank_cell  = {cur_color, CH_NUL};
    assign bs_col      = r_cur_col - 1'b1;
    assign rd_in_range = ({2'b00, i_cmd.target_row} < ROWS_C) &&
                         ({1'b0, i_cmd.target_col} < COLS_C);
    assign cur_addr    = cell_addr(r_cur_row, r_cur_col, r_top);
    assign bs_addr     = cell_addr(r_cur_row, bs_col, r_top);
    assign scroll_addr = ADDR_W'(r_srow) * ADDR_W'(COLUMNS) + r_cnt;

    // Configuration registers; the port never stalls.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= '0;
            r_bg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FG:  r_fg <= i_cfg_data;
                CFG_BG:  r_bg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Memory write port selection.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = cur_addr;
        ram_wdata = {cur_color, CH_SPACE};
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_cmd.func == FUNC_PRINT) begin
                    if (i_cmd.char_code == CH_BS) begin
                        ram_we    = (r_cur_col != '0);
                        ram_waddr = bs_addr;
                        ram_wdata = blank_cell;
                    end else if (i_cmd.char_code != CH_NUL && i_cmd.char_code != CH_NL) begin
                        ram_we    = 1'b1;
                        ram_wdata = {cur_color, i_cmd.char_code};
                    end
                end
            end
            S_LINE: begin
                ram_we = 1'b1;
            end
            S_SCROLL: begin
                ram_we    = 1'b1;
                ram_waddr = scroll_addr;
                ram_wdata = blank_cell;
            end
            S_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = r_cnt;
                ram_wdata = r_fill_data;
            end
            S_READ: begin
                ram_we = 1'b0;
            end
            default: ram_we = 1'b0;
        endcase
    end

    // Cell reads are issued only for in-range read commands.
    assign ram_re    = accept && (i_cmd.func == FUNC_READ) && rd_in_range;
    assign ram_raddr = cell_addr(i_cmd.target_row, i_cmd.target_col, r_top);

    tcw_screen_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Control state machine with cursor, scroll pointer and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_FILL;
            r_cur_row     <= '0;
            r_cur_col     <= '0;
            r_top         <= '0;
            r_cnt         <= '0;
            r_fill_data   <= '0;
            r_fill_report <= 1'b0;
            r_done        <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cell <= '0;
                        unique case (i_cmd.func)
                            FUNC_PRINT: begin
                                if (i_cmd.char_code == CH_NL) begin
                                    r_state <= S_LINE;
                                end else if (i_cmd.char_code == CH_NUL) begin
                                    r_done <= 1'b1;
                                end else if (i_cmd.char_code == CH_BS) begin
                                    if (r_cur_col != '0) begin
                                        r_cur_col <= bs_col;
                                    end
                                    r_done <= 1'b1;
                                end else if (r_cur_col != LAST_COL) begin
                                    r_cur_col <= r_cur_col + 1'b1;
                                    r_done    <= 1'b1;
                                end else if (r_cur_row != LAST_ROW) begin
                                    r_cur_col <= '0;
                                    r_cur_row <= r_cur_row + 1'b1;
                                    r_done    <= 1'b1;
                                end else begin
                                    // Wrap on the bottom row: scroll the screen.
                                    r_cur_col <= '0;
                                    r_srow    <= r_top;
                                    r_top     <= (r_top == LAST_ROW) ? '0 : r_top + 1'b1;
                                    r_cnt     <= '0;
                                    r_state   <= S_SCROLL;
                                end
                            end
                            FUNC_SET: begin
                                r_cur_row <= ({2'b00, i_cmd.target_row} < ROWS_C) ?
                                             i_cmd.target_row : LAST_ROW;
                                r_cur_col <= ({1'b0, i_cmd.target_col} < COLS_C) ?
                                             i_cmd.target_col : LAST_COL;
                                r_done    <= 1'b1;
                            end
                            FUNC_CLEAR: begin
                                r_cur_row     <= '0;
                                r_cur_col     <= '0;
                                r_top         <= '0;
                                r_cnt         <= '0;
                                r_fill_data   <= {i_cmd.clear_bg, {COLOR_W{1'b0}}, CH_NUL};
                                r_fill_report <= 1'b1;
                                r_state       <= S_FILL;
                            end
                            FUNC_READ: begin
                                if (rd_in_range) begin
                                    r_state <= S_READ;
                                end else begin
                                    r_done <= 1'b1;
                                end
                            end
                            default: r_done <= 1'b1;
                        endcase
                    end
                end
                S_LINE: begin
                    // One space per cycle until the line wraps.
                    if (r_cur_col != LAST_COL) begin
                        r_cur_col <= r_cur_col + 1'b1;
                    end else if (r_cur_row != LAST_ROW) begin
                        r_cur_col <= '0;
                        r_cur_row <= r_cur_row + 1'b1;
                        r_done    <= 1'b1;
                        r_state   <= S_IDLE;
                    end else begin
                        r_cur_col <= '0;
                        r_srow    <= r_top;
                        r_top     <= (r_top == LAST_ROW) ? '0 : r_top + 1'b1;
                        r_cnt     <= '0;
                        r_state   <= S_SCROLL;
                    end
                end
                S_SCROLL: begin
                    // Blank the row that has just become the bottom row.
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LAST_SCOL) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_FILL: begin
                    // Linear sweep over every cell, after reset or for clear screen.
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LAST_CELL) begin
                        r_done        <= r_fill_report;
                        r_fill_report <= 1'b0;
                        r_state       <= S_IDLE;
                    end
                end
                S_READ: begin
                    r_cell  <= ram_rdata;
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Results; the cursor registers hold the post-operation cursor while o_done is high.
    assign o_done              = r_done;
    assign o_result.cell_value = r_cell;
    assign o_result.cursor_row = r_cur_row;
    assign o_result.cursor_col = r_cur_col;

    // Checks.
    `ASSERT_ALWAYS(a_pos_range, i_clk, i_rst_n,
        (r_cur_row <= LAST_ROW) && (r_cur_col <= LAST_COL) && (r_top <= LAST_ROW))
    `ASSERT_NEXT(a_set_done, i_clk, i_rst_n,
        start && !busy && (i_cmd.func == FUNC_SET), o_done && !busy)
    `ASSERT_ALWAYS(a_done_idle, i_clk, i_rst_n, !o_done || (r_state == S_IDLE))
    `ASSERT_ALWAYS(a_cell_from_read, i_clk, i_rst_n,
        !(o_done && (o_result.cell_value != '0)) || ($past(r_state) == S_READ))

endmodule

[hw/rtl/tcw_screen_ram.sv]
// Screen cell memory: one write port, one read port, registered read data.
// Depends on tcw_pkg for the cell width.
module tcw_screen_ram
    import tcw_pkg::*;
#(
    parameter int DEPTH  = DEF_ROWS * DEF_COLUMNS,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [CELL_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [CELL_W-1:0] o_rdata
);

    logic [CELL_W-1:0] r_mem [DEPTH];
    logic [CELL_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the read data is registered and updated only while i_re is high.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[verif/console_shadow_pkg.sv]
`timescale 1ns / 100ps
// Shadow model of the text console writer: screen store, cursor, colors and the
// queue of results still owed by the block. Depends on tcw_pkg for the types.
package console_shadow_pkg;
    import tcw_pkg::*;

    localparam int SCREEN_COLS  = DEF_COLUMNS;
    localparam int SCREEN_ROWS  = DEF_ROWS;
    localparam int SCREEN_CELLS = SCREEN_COLS * SCREEN_ROWS;

    class console_shadow;
        logic [CELL_W-1:0]  cells [SCREEN_CELLS];
        int unsigned        row_pos;
        int unsigned        col_pos;
        logic [COLOR_W-1:0] fg;
        logic [COLOR_W-1:0] bg;
        t_result            pending_results [$];
        int unsigned        mismatches;

        // The block comes out of reset with a blank screen and black colors.
        function new();
            foreach (cells[i]) cells[i] = '0;
            row_pos    = 0;
            col_pos    = 0;
            fg         = '0;
            bg         = '0;
            mismatches = 0;
        endfunction

        // A color register transfer; unknown indexes are dropped.
        function void write_color(logic [CFG_IDX_W-1:0] index, logic [COLOR_W-1:0] value);
            if (index == CFG_FG)
                fg = value;
            else if (index == CFG_BG)
                bg = value;
        endfunction

        function logic [CELL_W-1:0] colored_cell(logic [CHAR_W-1:0] ch);
            return {bg, fg, ch};
        endfunction

        // Move every row up one and blank the bottom row in the current colors.
        function void scroll_screen();
            for (int i = 0; i < SCREEN_CELLS - SCREEN_COLS; i++)
                cells[i] = cells[i + SCREEN_COLS];
            for (int i = SCREEN_CELLS - SCREEN_COLS; i < SCREEN_CELLS; i++)
                cells[i] = colored_cell(CH_NUL);
        endfunction

        // Write one cell at the cursor, then advance with column wrap and scroll.
        function void put_char(logic [CHAR_W-1:0] ch);
            cells[row_pos * SCREEN_COLS + col_pos] = colored_cell(ch);
            col_pos++;
            if (col_pos >= SCREEN_COLS) begin
                col_pos = 0;
                row_pos++;
                if (row_pos >= SCREEN_ROWS) begin
                    scroll_screen();
                    row_pos = SCREEN_ROWS - 1;
                end
            end
        endfunction

        // Apply one accepted command and queue the result it owes.
        function void note_command(t_cmd cmd);
            logic [CELL_W-1:0] cell_read;
            int unsigned       span;
            t_result           owed;
            cell_read = '0;
            case (cmd.func)
                FUNC_PRINT: begin
                    if (cmd.char_code == CH_BS) begin
                        // Backspace at the left edge is a no-op.
                        if (col_pos != 0) begin
                            col_pos--;
                            cells[row_pos * SCREEN_COLS + col_pos] = colored_cell(CH_NUL);
                        end
                    end else if (cmd.char_code == CH_NL) begin
                        span = SCREEN_COLS - col_pos;
                        repeat (span) put_char(CH_SPACE);
                    end else if (cmd.char_code != CH_NUL) begin
                        put_char(cmd.char_code);
                    end
                end
                FUNC_SET: begin
                    row_pos = (cmd.target_row < SCREEN_ROWS) ? cmd.target_row : SCREEN_ROWS - 1;
                    col_pos = (cmd.target_col < SCREEN_COLS) ? cmd.target_col : SCREEN_COLS - 1;
                end
                FUNC_CLEAR: begin
                    foreach (cells[i]) cells[i] = {cmd.clear_bg, {COLOR_W{1'b0}}, CH_NUL};
                    row_pos = 0;
                    col_pos = 0;
                end
                default: begin
                    if (cmd.target_row < SCREEN_ROWS && cmd.target_col < SCREEN_COLS)
                        cell_read = cells[cmd.target_row * SCREEN_COLS + cmd.target_col];
                end
            endcase
            owed.cell_value = cell_read;
            owed.cursor_row = row_pos[ROW_W-1:0];
            owed.cursor_col = col_pos[COL_W-1:0];
            pending_results.push_back(owed);
        endfunction

        // Compare one result from the block with the oldest owed result.
        function void check_result(t_result got);
            t_result owed;
            if (pending_results.size() == 0) begin
                $error("unexpected result: cell %h row %0d col %0d",
                       got.cell_value, got.cursor_row, got.cursor_col);
                mismatches++;
                return;
            end
            owed = pending_results.pop_front();
            if (got.cell_value !== owed.cell_value) begin
                $error("cell_value: expected %h, actual %h", owed.cell_value, got.cell_value);
                mismatches++;
            end
            if (got.cursor_row !== owed.cursor_row) begin
                $error("cursor_row: expected %0d, actual %0d", owed.cursor_row, got.cursor_row);
                mismatches++;
            end
            if (got.cursor_col !== owed.cursor_col) begin
                $error("cursor_col: expected %0d, actual %0d", owed.cursor_col, got.cursor_col);
                mismatches++;
            end
        endfunction
    endclass

endpackage

[verif/tb_text_console_writer_top.sv]
`timescale 1ns / 100ps
// Self-checking bench for text_console_writer_top: directed and random commands
// under several color settings. Depends on tcw_pkg and console_shadow_pkg.
module tb_text_console_writer_top;
    import tcw_pkg::*;
    import console_shadow_pkg::*;

    localparam int STALL_LIMIT     = 20000;
    localparam int SETTLE_CYCLES   = 2 * SCREEN_CELLS + 100;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int PHASE_COUNT     = 6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 start       = 1'b0;
    t_cmd                 i_cmd       = '0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [COLOR_W-1:0]   i_cfg_data  = '0;
    logic                 busy;
    logic                 o_done;
    t_result              o_result;
    logic                 o_cfg_ready;

    console_shadow screen_shadow = new();
    int unsigned   quiet_cycles  = 0;
    int unsigned   idle_pct      = 0;

    text_console_writer_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_cmd       (i_cmd),
        .busy        (busy),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Track every transfer at the clock edge and stop the run if the block hangs.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done)
                screen_shadow.check_result(o_result);
            if (start && !busy)
                screen_shadow.note_command(i_cmd);
            if (i_cfg_valid && o_cfg_ready)
                screen_shadow.write_color(i_cfg_index, i_cfg_data);
            if (o_done || (start && !busy) || (i_cfg_valid && o_cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("text_console_writer_top test failed");
                $finish;
            end
        end
    end

    function automatic t_cmd command_of(logic [FUNC_W-1:0] func, logic [CHAR_W-1:0] ch,
                                        logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                                        logic [COLOR_W-1:0] clear_bg);
        t_cmd cmd;
        cmd.func       = func;
        cmd.char_code  = ch;
        cmd.target_row = row;
        cmd.target_col = col;
        cmd.clear_bg   = clear_bg;
        return cmd;
    endfunction

    // Random command: mostly prints and cursor moves near the bottom so that
    // wraps and scrolls happen often, with reads spread over the whole range.
    function automatic t_cmd random_command();
        t_cmd        cmd;
        logic [31:0] noise;
        int unsigned pick;
        int unsigned char_pick;
        noise = $urandom;
        cmd   = noise[$bits(t_cmd)-1:0];
        pick  = $urandom_range(99);
        if (pick < 50) begin
            cmd.func  = FUNC_PRINT;
            char_pick = $urandom_range(99);
            if (char_pick < 12)
                cmd.char_code = CH_NL;
            else if (char_pick < 22)
                cmd.char_code = CH_BS;
            else if (char_pick < 25)
                cmd.char_code = CH_NUL;
            else
                cmd.char_code = CHAR_W'($urandom_range(255));
        end else if (pick < 68) begin
            cmd.func = FUNC_SET;
            if ($urandom_range(1))
                cmd.target_row = ROW_W'($urandom_range(31, SCREEN_ROWS - 4));
            if ($urandom_range(2) == 0)
                cmd.target_col = COL_W'($urandom_range(127, SCREEN_COLS - 4));
        end else if (pick < 70) begin
            cmd.func = FUNC_CLEAR;
        end else begin
            cmd.func = FUNC_READ;
            if ($urandom_range(4) != 0) begin
                cmd.target_row = ROW_W'($urandom_range(SCREEN_ROWS - 1));
                cmd.target_col = COL_W'($urandom_range(SCREEN_COLS - 1));
            end
        end
        return cmd;
    endfunction

    // Hold the command on the port until the block takes it, after a random gap.
    task automatic send_command(input t_cmd cmd);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            i_cmd <= random_command();
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= cmd;
        do @(posedge i_clk); while (busy);
    endtask

    // Leaves valid high; the caller lowers it after the last write.
    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [COLOR_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic set_colors(input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg);
        write_register(CFG_FG, fg);
        write_register(CFG_BG, bg);
        // An unused index must leave both colors alone.
        write_register(CFG_UNUSED, COLOR_W'($urandom_range(15)));
        i_cfg_valid <= 1'b0;
    endtask

    // Stop sending, then wait for every owed result and for busy to drop.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (screen_shadow.pending_results.size() != 0) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    initial begin
        t_cmd        directed [$];
        t_cmd        cmd;
        int unsigned sent;
        logic [COLOR_W-1:0] phase_fg;
        logic [COLOR_W-1:0] phase_bg;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: special characters, wrap and scroll, saturation,
        // out-of-range reads and clears at both background extremes.
        set_colors(4'hF, 4'hA);
        directed.push_back(command_of(FUNC_READ,  CH_NUL, 5'd0,  7'd0,   4'h0));
        directed.push_back(command_of(FUNC_PRINT, 8'h41,  5'd0,  7'd0,   4'h0));
        directed.push_back(command_of(FUNC_PRINT, CH_NUL, 5'd0,  7'd0,   4'h0));
        directed.push_back(command_of(FUNC_PRINT, CH_BS,  5'd0,  7'd0,   4'h0));
        directed.push_back(command_of(FUNC_PRINT, CH_BS,  5'd0,  7'd0,   4'h0));
        directed.push_back(command_of(FUNC_PRINT, 8'hFF,  5'd0,  7'd0,   4'h0));
        directed.push_back(command_of(FUNC_PRINT, 8'h01,  5'd0,  7'd0,   4'h0));
        directed.push_back(command_of(FUNC_PRINT, CH_NL,  5'd0,  7'd0,   4'h0));
        directed.push_back(command_of(FUNC_READ,  CH_NUL, 5'd0,  7'd1,   4'h0));
        directed.push_back(command_of(FUNC_READ,  CH_NUL, 5'd0,  7'd2,   4'h0));
        directed.push_back(command_of(FUNC_READ,  CH_NUL, 5'd0,  7'd79,  4'h0));
        directed.push_back(command_of(FUNC_SET,   CH_NUL, 5'd31, 7'd127, 4'h0));
        directed.push_back(command_of(FUNC_PRINT, 8'h5A,  5'd0,  7'd0,   4'h0));
        directed.push_back(command_of(FUNC_READ,  CH_NUL, 5'd23, 7'd79,  4'h0));
        directed.push_back(command_of(FUNC_READ,  CH_NUL, 5'd24, 7'd0,   4'h0));
        directed.push_back(command_of(FUNC_SET,   CH_NUL, 5'd24, 7'd5,   4'h0));
        directed.push_back(command_of(FUNC_PRINT, CH_NL,  5'd0,  7'd0,   4'h0));
        directed.push_back(command_of(FUNC_READ,  CH_NUL, 5'd25, 7'd0,   4'h0));
        directed.push_back(command_of(FUNC_READ,  CH_NUL, 5'd0,  7'd80,  4'h0));
        directed.push_back(command_of(FUNC_READ,  CH_NUL, 5'd31, 7'd127, 4'h0));
        directed.push_back(command_of(FUNC_CLEAR, CH_NUL, 5'd0,  7'd0,   4'hF));
        directed.push_back(command_of(FUNC_READ,  CH_NUL, 5'd24, 7'd79,  4'h0));
        directed.push_back(command_of(FUNC_SET,   CH_NUL, 5'd0,  7'd79,  4'h0));
        directed.push_back(command_of(FUNC_PRINT, 8'h7E,  5'd0,  7'd0,   4'h0));
        directed.push_back(command_of(FUNC_CLEAR, CH_NUL, 5'd0,  7'd0,   4'h0));
        foreach (directed[i]) send_command(directed[i]);
        drain_results();

        // Random phases, each with its own colors and sender gap rate.
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: begin phase_fg = 4'h0; phase_bg = 4'h0; idle_pct = 0;  end
                1: begin phase_fg = 4'hF; phase_bg = 4'hF; idle_pct = 75; end
                2: begin phase_fg = COLOR_W'($urandom_range(15));
                         phase_bg = COLOR_W'($urandom_range(15));
                         idle_pct = 20; end
                3: begin phase_fg = 4'hF; phase_bg = 4'h0; idle_pct = 0;  end
                4: begin phase_fg = COLOR_W'($urandom_range(15));
                         phase_bg = COLOR_W'($urandom_range(15));
                         idle_pct = 75; end
                default: begin phase_fg = 4'h0; phase_bg = 4'hF; idle_pct = 20; end
            endcase
            set_colors(phase_fg, phase_bg);
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                cmd = random_command();
                send_command(cmd);
                if (!(cmd.func == FUNC_PRINT && cmd.char_code == CH_NUL))
                    sent++;
            end
            drain_results();
        end

        // Let any stray result show up before the verdict.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (screen_shadow.mismatches == 0 && screen_shadow.pending_results.size() == 0)
            $display("text_console_writer_top test passed");
        else
            $display("text_console_writer_top test failed");
        $finish;
    end

endmodule
